// ===== design/binary_min_heap_macros.svh =====
// Assertion macros for the binary min-heap block.
`ifndef BINARY_MIN_HEAP_MACROS_SVH
`define BINARY_MIN_HEAP_MACROS_SVH
`ifndef SYNTHESIS
`define BMH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BMH_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BMH_ASSERT_IMP(lbl, ante, cons, msg)
`define BMH_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/bmh_pkg.sv =====
// Shared types and constants of the binary min-heap block.
`timescale 1ns / 1ps
package bmh_pkg;
	localparam int unsigned HEAP_DEPTH_DEF = 16;
	localparam int unsigned KEY_W = 32;
	localparam int unsigned OCC_W = 5;

	typedef logic signed [KEY_W-1:0] key_t;

	localparam key_t INT_MAX = 32'sh7FFF_FFFF;

	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2
	} status_t;

	typedef struct packed {
		logic op;
		key_t key_in;
	} heap_cmd_t;

	typedef struct packed {
		key_t             key_out;
		status_t          status;
		logic [OCC_W-1:0] occupancy;
	} heap_rsp_t;
endpackage

// ===== design/bmh_store.sv =====
// Heap key store: one write port, two registered read ports.
`timescale 1ns / 1ps
module bmh_store import bmh_pkg::*; #(
	parameter int unsigned DEPTH = HEAP_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  key_t                       wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr0,
	input  logic [$clog2(DEPTH)-1:0]   raddr1,
	output key_t                       rdata0,
	output key_t                       rdata1
);
	key_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end
endmodule

// ===== design/binary_min_heap.sv =====
// Insert: accept, then S_UP_STEP and S_UP_CMP per level climbed.
// Extract: S_EX_LD fetches root and last entry; S_DN_STEP, S_DN_L, S_DN_R per level
// descended; S_DN_STEP, S_DN_L at a leaf. Overflow and empty results come in the cycle
// after start. Pace is set by the store's registered read and one shared key comparator.
// Reset clears the count and the sequencer; the key store holds no reset value.
// The result strobe lasts one cycle and cannot be stalled; the next word may start then.
`timescale 1ns / 1ps
`include "binary_min_heap_macros.svh"
module binary_min_heap import bmh_pkg::*; #(
	parameter int unsigned HEAP_DEPTH = HEAP_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  heap_cmd_t cmd,
	output logic      busy,
	output logic      done,
	output heap_rsp_t result
);
	localparam int unsigned IW = $clog2(HEAP_DEPTH);
	localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_EX_LD   = 7'b0000010,
		S_UP_STEP = 7'b0000100,
		S_UP_CMP  = 7'b0001000,
		S_DN_STEP = 7'b0010000,
		S_DN_L    = 7'b0100000,
		S_DN_R    = 7'b1000000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [IW-1:0]   pos_q;
	key_t            key_q;
	key_t            best_q;
	logic            take_left_q;
	heap_rsp_t       rsp_q;
	logic            done_q;

	logic [IW-1:0]   ra0, ra1, wa;
	logic            we;
	key_t            wd, rd0, rd1;
	key_t            cmp_a, cmp_b;
	logic            lt;

	logic [IW-1:0]   pos_m1, parent;
	logic [IW+1:0]   left_w, right_w, cnt_w;
	logic            left_ok, right_ok, use_r;
	logic [CW-1:0]   cnt_m1;
	logic [CW+OCC_W-1:0] cnt_ext;
	logic [OCC_W-1:0] occ_now;
	logic            full, empty;

	assign pos_m1   = pos_q - 1'b1;
	assign parent   = pos_m1 >> 1;
	assign left_w   = {1'b0, pos_q, 1'b1};
	assign right_w  = left_w + 1'b1;
	assign cnt_w    = {{(IW + 2 - CW){1'b0}}, count_q};
	assign left_ok  = left_w < cnt_w;
	assign right_ok = right_w < cnt_w;
	assign cnt_m1   = count_q - 1'b1;
	assign cnt_ext  = {{OCC_W{1'b0}}, count_q};
	assign occ_now  = cnt_ext[OCC_W-1:0];
	assign full     = count_q == CW'(HEAP_DEPTH);
	assign empty    = count_q == '0;
	assign use_r    = right_ok && lt;

	// shared key comparator
	always_comb begin
		unique case (state_q)
			S_DN_L: begin
				cmp_a = rd0;
				cmp_b = key_q;
			end
			S_DN_R: begin
				cmp_a = rd1;
				cmp_b = best_q;
			end
			default: begin
				cmp_a = key_q;
				cmp_b = rd0;
			end
		endcase
	end
	assign lt = cmp_a < cmp_b;

	// store addressing; the moving key lives in key_q until its slot is found
	always_comb begin
		ra0 = '0;
		ra1 = cnt_m1[IW-1:0];
		we  = 1'b0;
		wa  = pos_q;
		wd  = key_q;
		unique case (state_q)
			S_UP_STEP: begin
				ra0 = parent;
				we  = pos_q == '0;
			end
			S_UP_CMP: begin
				we = 1'b1;
				wd = lt ? rd0 : key_q;
			end
			S_DN_STEP: begin
				ra0 = left_w[IW-1:0];
				ra1 = right_w[IW-1:0];
			end
			S_DN_L: begin
				ra0 = left_w[IW-1:0];
				ra1 = right_w[IW-1:0];
				we  = !left_ok;
			end
			S_DN_R: begin
				we = 1'b1;
				wd = use_r ? rd1 : (take_left_q ? rd0 : key_q);
			end
			default: begin
				ra0 = '0;
			end
		endcase
	end

	bmh_store #(
		.DEPTH(HEAP_DEPTH)
	) u_store (
		.clk    (clk),
		.we     (we),
		.waddr  (wa),
		.wdata  (wd),
		.raddr0 (ra0),
		.raddr1 (ra1),
		.rdata0 (rd0),
		.rdata1 (rd1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			done_q      <= 1'b0;
			pos_q       <= '0;
			key_q       <= '0;
			best_q      <= '0;
			take_left_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (cmd.op == OP_INSERT) begin
							if (full) begin
								rsp_q.key_out   <= '0;
								rsp_q.status    <= ST_OVERFLOW;
								rsp_q.occupancy <= occ_now;
								done_q          <= 1'b1;
							end else begin
								key_q         <= cmd.key_in;
								pos_q         <= count_q[IW-1:0];
								count_q       <= count_q + 1'b1;
								rsp_q.key_out <= '0;
								rsp_q.status  <= ST_OK;
								state_q       <= S_UP_STEP;
							end
						end else begin
							if (empty) begin
								rsp_q.key_out   <= INT_MAX;
								rsp_q.status    <= ST_EMPTY;
								rsp_q.occupancy <= occ_now;
								done_q          <= 1'b1;
							end else begin
								count_q      <= cnt_m1;
								rsp_q.status <= ST_OK;
								state_q      <= S_EX_LD;
							end
						end
					end
				end
				S_EX_LD: begin
					// root leaves as the result, last entry becomes the moving key
					rsp_q.key_out <= rd0;
					key_q         <= rd1;
					pos_q         <= '0;
					if (empty) begin
						rsp_q.occupancy <= occ_now;
						done_q          <= 1'b1;
						state_q         <= S_IDLE;
					end else begin
						state_q <= S_DN_STEP;
					end
				end
				S_UP_STEP: begin
					if (pos_q == '0) begin
						rsp_q.occupancy <= occ_now;
						done_q          <= 1'b1;
						state_q         <= S_IDLE;
					end else begin
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (lt) begin
						pos_q   <= parent;
						state_q <= S_UP_STEP;
					end else begin
						rsp_q.occupancy <= occ_now;
						done_q          <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				S_DN_STEP: begin
					state_q <= S_DN_L;
				end
				S_DN_L: begin
					if (!left_ok) begin
						rsp_q.occupancy <= occ_now;
						done_q          <= 1'b1;
						state_q         <= S_IDLE;
					end else begin
						best_q      <= lt ? rd0 : key_q;
						take_left_q <= lt;
						state_q     <= S_DN_R;
					end
				end
				S_DN_R: begin
					if (use_r) begin
						pos_q   <= right_w[IW-1:0];
						state_q <= S_DN_STEP;
					end else if (take_left_q) begin
						pos_q   <= left_w[IW-1:0];
						state_q <= S_DN_STEP;
					end else begin
						rsp_q.occupancy <= occ_now;
						done_q          <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = rsp_q;

	`BMH_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(HEAP_DEPTH), "heap count above depth")
	`BMH_ASSERT_IMP(a_done_idle, done_q, state_q == S_IDLE, "result strobe while busy")
	`BMH_ASSERT_NXT(a_accept_moves, start && !busy, busy || done, "accepted word dropped")
	`BMH_ASSERT_IMP(a_empty_key, done && result.status == ST_EMPTY, result.key_out == INT_MAX,
		"empty extract without maximum key")
endmodule

// ===== sim/tb_binary_min_heap.sv =====
// Self-checking testbench for the binary min-heap against a shadow heap.
`timescale 1ns / 1ps
module tb_binary_min_heap;
	import bmh_pkg::*;

	localparam int DEPTH = HEAP_DEPTH_DEF;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 40;
	localparam int REPORT_MAX = 10;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	heap_cmd_t cmd = '0;
	logic      busy;
	logic      done;
	heap_rsp_t result;

	binary_min_heap #(.HEAP_DEPTH(DEPTH)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the heap contents
	key_t shadow_keys [DEPTH];
	int   shadow_count = 0;

	heap_cmd_t cmd_backlog [$];
	heap_rsp_t pending_rsp [$];

	logic      cmd_taken = 1'b0;
	int        words_sent = 0;
	int        stall_cycles = 0;
	int        mismatches = 0;
	int        n_insert = 0;
	int        n_extract = 0;
	int        n_overflow = 0;
	int        n_empty = 0;
	heap_rsp_t want;

	key_t directed_keys [DEPTH] = '{
		32'sd0, INT_MAX, 32'sh8000_0000, -32'sd1, 32'sd1, 32'sd5, 32'sd5, 32'sd5,
		32'sd100, -32'sd100, 32'sd3, 32'sd2, 32'sd7, -32'sd7, 32'sh8000_0000, INT_MAX
	};

	function automatic heap_rsp_t min_heap_update(heap_cmd_t c);
		heap_rsp_t r;
		int        pos;
		int        kid;
		int        best;
		bit        settled;
		key_t      tmp;
		r.key_out = '0;
		r.status = ST_OK;
		if (c.op == OP_INSERT) begin
			if (shadow_count >= DEPTH) begin
				r.status = ST_OVERFLOW;
			end else begin
				pos = shadow_count;
				shadow_keys[pos] = c.key_in;
				shadow_count++;
				// climb while the parent holds a strictly larger key
				while (pos != 0 && shadow_keys[pos] < shadow_keys[(pos - 1) / 2]) begin
					tmp = shadow_keys[pos];
					shadow_keys[pos] = shadow_keys[(pos - 1) / 2];
					shadow_keys[(pos - 1) / 2] = tmp;
					pos = (pos - 1) / 2;
				end
			end
		end else if (shadow_count == 0) begin
			r.key_out = INT_MAX;
			r.status = ST_EMPTY;
		end else begin
			r.key_out = shadow_keys[0];
			shadow_count--;
			if (shadow_count > 0) begin
				shadow_keys[0] = shadow_keys[shadow_count];
				pos = 0;
				settled = 1'b0;
				while (!settled) begin
					best = pos;
					kid = 2 * pos + 1;
					// left child wins a tie between the two children
					if (kid < shadow_count && shadow_keys[kid] < shadow_keys[best])
						best = kid;
					if (kid + 1 < shadow_count && shadow_keys[kid + 1] < shadow_keys[best])
						best = kid + 1;
					if (best == pos) begin
						settled = 1'b1;
					end else begin
						tmp = shadow_keys[pos];
						shadow_keys[pos] = shadow_keys[best];
						shadow_keys[best] = tmp;
						pos = best;
					end
				end
			end
		end
		r.occupancy = shadow_count[OCC_W-1:0];
		return r;
	endfunction

	function automatic key_t pick_key();
		case ($urandom_range(0, 9)) inside
			[0:3]:   return key_t'($urandom);
			[4:6]:   return key_t'($urandom_range(0, 8)) - 32'sd4;
			7:       return ($urandom_range(0, 1) != 0) ? INT_MAX : key_t'(32'sh8000_0000);
			8:       return INT_MAX - key_t'($urandom_range(0, 3));
			default: return key_t'(32'sh8000_0000) + key_t'($urandom_range(0, 3));
		endcase
	endfunction

	function automatic void queue_word(logic op, key_t key);
		heap_cmd_t w;
		w.op = op;
		w.key_in = key;
		cmd_backlog.push_back(w);
	endfunction

	function automatic void report_bad(heap_rsp_t exp_rsp, heap_rsp_t got, bit stray);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			if (stray) begin
				$display("%0t: result word with none expected: key %0d status %0d occ %0d",
					$realtime, got.key_out, got.status, got.occupancy);
			end else begin
				$write("%0t: mismatch: want key %0d status %0d occ %0d,",
					$realtime, exp_rsp.key_out, exp_rsp.status, exp_rsp.occupancy);
				$display(" got key %0d status %0d occ %0d",
					got.key_out, got.status, got.occupancy);
			end
		end
	endfunction

	// driver: hold a word until taken, otherwise idle at random or advance
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || cmd_taken) begin
			if (cmd_backlog.size() != 0 &&
					((words_sent >= 200 && words_sent < 320) || $urandom_range(0, 99) >= 30)) begin
				cmd <= cmd_backlog.pop_front();
				start <= 1'b1;
				words_sent++;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check results, predict on accept, watch for a hang
	always @(posedge clk) begin
		cmd_taken <= arst_n && start && !busy;
		if (arst_n) begin
			if (done) begin
				if (pending_rsp.size() == 0) begin
					report_bad(result, result, 1'b1);
				end else begin
					want = pending_rsp.pop_front();
					if (result.key_out !== want.key_out || result.status !== want.status ||
							result.occupancy !== want.occupancy)
						report_bad(want, result, 1'b0);
				end
			end
			if (start && !busy) begin
				want = min_heap_update(cmd);
				pending_rsp.push_back(want);
				if (cmd.op == OP_INSERT) n_insert++;
				else n_extract++;
				if (want.status == ST_OVERFLOW) n_overflow++;
				if (want.status == ST_EMPTY) n_empty++;
			end
			if (done || (start && !busy)) stall_cycles = 0;
			else stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d quiet cycles", stall_cycles);
				$display("tb_binary_min_heap: errors");
				$finish;
			end
		end
	end

	initial begin
		int ins_pct;
		// directed: empty extract, fill with extremes and ties, refuse one, pull some
		queue_word(OP_EXTRACT, pick_key());
		foreach (directed_keys[i])
			queue_word(OP_INSERT, directed_keys[i]);
		queue_word(OP_INSERT, 32'sd42);
		for (int i = 0; i < 7; i++)
			queue_word(OP_EXTRACT, INT_MAX);
		// random: bursts leaning to fill, mix or drain so full and empty recur
		for (int b = 0; b < 26; b++) begin
			case ($urandom_range(0, 2))
				0:       ins_pct = 85;
				1:       ins_pct = 50;
				default: ins_pct = 15;
			endcase
			for (int i = 0; i < 20; i++)
				queue_word(($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_EXTRACT, pick_key());
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || start || pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d inserts (%0d refused on full) and %0d extracts (%0d on empty)",
			n_insert, n_overflow, n_extract, n_empty);
		$display("mismatched or stray result words: %0d", mismatches);
		if (mismatches == 0)
			$display("tb_binary_min_heap: clean");
		else
			$display("tb_binary_min_heap: errors");
		$finish;
	end
endmodule
